>>> design/rv32i_instruction_decoder_assert.svh
// assertion macros for the rv32i instruction decoder
// the including scope must provide clk_i and rst_ni
`ifndef RV32I_INSTRUCTION_DECODER_ASSERT_SVH
`define RV32I_INSTRUCTION_DECODER_ASSERT_SVH

// same-cycle implication
`define RVDEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RVDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rvdec_pkg.sv
// shared types and encodings for the rv32i instruction decoder
// no dependencies
`default_nettype none

package rvdec_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned FMT_W  = 3;
  localparam int unsigned IDX_W  = 6;

  typedef enum logic [FMT_W-1:0] {
    FMT_R   = 3'd0,
    FMT_I   = 3'd1,
    FMT_S   = 3'd2,
    FMT_B   = 3'd3,
    FMT_U   = 3'd4,
    FMT_J   = 3'd5,
    FMT_BAD = 3'd6
  } rvdec_fmt_e;

  typedef enum logic [IDX_W-1:0] {
    IDX_LUI   = 6'd0,
    IDX_AUIPC = 6'd1,
    IDX_JAL   = 6'd2,
    IDX_JALR  = 6'd3,
    IDX_BEQ   = 6'd4,
    IDX_BNE   = 6'd5,
    IDX_BLT   = 6'd6,
    IDX_BGE   = 6'd7,
    IDX_BLTU  = 6'd8,
    IDX_BGEU  = 6'd9,
    IDX_LB    = 6'd10,
    IDX_LH    = 6'd11,
    IDX_LW    = 6'd12,
    IDX_LBU   = 6'd13,
    IDX_LHU   = 6'd14,
    IDX_SB    = 6'd15,
    IDX_SH    = 6'd16,
    IDX_SW    = 6'd17,
    IDX_ADDI  = 6'd18,
    IDX_SLTI  = 6'd19,
    IDX_SLTIU = 6'd20,
    IDX_XORI  = 6'd21,
    IDX_ORI   = 6'd22,
    IDX_ANDI  = 6'd23,
    IDX_SLLI  = 6'd24,
    IDX_SRLI  = 6'd25,
    IDX_SRAI  = 6'd26,
    IDX_ADD   = 6'd27,
    IDX_SUB   = 6'd28,
    IDX_SLL   = 6'd29,
    IDX_SLT   = 6'd30,
    IDX_SLTU  = 6'd31,
    IDX_XOR   = 6'd32,
    IDX_SRL   = 6'd33,
    IDX_SRA   = 6'd34,
    IDX_OR    = 6'd35,
    IDX_AND   = 6'd36,
    IDX_NONE  = 6'd37
  } rvdec_idx_e;

  // major opcodes
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // load / store width funct3
  localparam logic [2:0] F3_BYTE   = 3'd0;
  localparam logic [2:0] F3_HALF   = 3'd1;
  localparam logic [2:0] F3_WORD   = 3'd2;
  localparam logic [2:0] F3_BYTE_U = 3'd4;
  localparam logic [2:0] F3_HALF_U = 3'd5;

  // alu funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  typedef struct packed {
    rvdec_fmt_e        fmt;
    logic [WORD_W-1:0] imm;
    rvdec_idx_e        idx;
  } rvdec_res_t;

endpackage

`default_nettype wire

>>> design/rvdec_in_if.sv
// request channel carrying one instruction word
// depends on rvdec_pkg
`default_nettype none

interface rvdec_in_if;
  logic                         valid;
  logic                         ready;
  logic [rvdec_pkg::WORD_W-1:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

`default_nettype wire

>>> design/rvdec_out_if.sv
// result channel carrying format, immediate and instruction index
// depends on rvdec_pkg
`default_nettype none

interface rvdec_out_if;
  logic                         valid;
  logic                         ready;
  logic [rvdec_pkg::FMT_W-1:0]  format_code;
  logic [rvdec_pkg::WORD_W-1:0] immediate;
  logic [rvdec_pkg::IDX_W-1:0]  instr_index;

  modport source (output valid, output format_code, output immediate, output instr_index,
                  input ready);
  modport sink (input valid, input format_code, input immediate, input instr_index,
                output ready);
endinterface

`default_nettype wire

>>> design/rvdec_in_stage.sv
// input register: captures the instruction word of each request
// depends on rvdec_pkg and rvdec_in_if
`default_nettype none

module rvdec_in_stage (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  rvdec_in_if.sink                          req_i,
  input  wire logic                         down_ready_i,
  output logic                              valid_o,
  output logic [rvdec_pkg::WORD_W-1:0]      word_o
);

  logic                         valid_q, valid_d;
  logic [rvdec_pkg::WORD_W-1:0] word_q;
  logic                         take;

  // free slot, or the held word moves on this cycle
  assign req_i.ready = !valid_q || down_ready_i;
  assign take        = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (down_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= req_i.instr_word;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

>>> design/rvdec_decode.sv
// decode logic: format, immediate and instruction index of one word
// depends on rvdec_pkg
`default_nettype none

module rvdec_decode (
  input  wire logic [rvdec_pkg::WORD_W-1:0] word_i,
  output rvdec_pkg::rvdec_res_t             res_o
);

  logic [6:0]            opcode;
  logic [2:0]            f3;
  logic                  alt;
  rvdec_pkg::rvdec_fmt_e fmt;
  rvdec_pkg::rvdec_idx_e idx;
  logic [rvdec_pkg::WORD_W-1:0] imm;

  assign opcode = word_i[6:0];
  assign f3     = word_i[14:12];
  assign alt    = word_i[30];

  always_comb begin
    fmt = rvdec_pkg::FMT_BAD;
    idx = rvdec_pkg::IDX_NONE;
    unique case (opcode)
      rvdec_pkg::OP_LUI: begin
        fmt = rvdec_pkg::FMT_U;
        idx = rvdec_pkg::IDX_LUI;
      end
      rvdec_pkg::OP_AUIPC: begin
        fmt = rvdec_pkg::FMT_U;
        idx = rvdec_pkg::IDX_AUIPC;
      end
      rvdec_pkg::OP_JAL: begin
        fmt = rvdec_pkg::FMT_J;
        idx = rvdec_pkg::IDX_JAL;
      end
      // funct3 of jalr is not checked
      rvdec_pkg::OP_JALR: begin
        fmt = rvdec_pkg::FMT_I;
        idx = rvdec_pkg::IDX_JALR;
      end
      rvdec_pkg::OP_BRANCH: begin
        fmt = rvdec_pkg::FMT_B;
        unique case (f3)
          rvdec_pkg::F3_BEQ:  idx = rvdec_pkg::IDX_BEQ;
          rvdec_pkg::F3_BNE:  idx = rvdec_pkg::IDX_BNE;
          rvdec_pkg::F3_BLT:  idx = rvdec_pkg::IDX_BLT;
          rvdec_pkg::F3_BGE:  idx = rvdec_pkg::IDX_BGE;
          rvdec_pkg::F3_BLTU: idx = rvdec_pkg::IDX_BLTU;
          rvdec_pkg::F3_BGEU: idx = rvdec_pkg::IDX_BGEU;
          default:            idx = rvdec_pkg::IDX_NONE;
        endcase
      end
      rvdec_pkg::OP_LOAD: begin
        fmt = rvdec_pkg::FMT_I;
        unique case (f3)
          rvdec_pkg::F3_BYTE:   idx = rvdec_pkg::IDX_LB;
          rvdec_pkg::F3_HALF:   idx = rvdec_pkg::IDX_LH;
          rvdec_pkg::F3_WORD:   idx = rvdec_pkg::IDX_LW;
          rvdec_pkg::F3_BYTE_U: idx = rvdec_pkg::IDX_LBU;
          rvdec_pkg::F3_HALF_U: idx = rvdec_pkg::IDX_LHU;
          default:              idx = rvdec_pkg::IDX_NONE;
        endcase
      end
      rvdec_pkg::OP_STORE: begin
        fmt = rvdec_pkg::FMT_S;
        unique case (f3)
          rvdec_pkg::F3_BYTE: idx = rvdec_pkg::IDX_SB;
          rvdec_pkg::F3_HALF: idx = rvdec_pkg::IDX_SH;
          rvdec_pkg::F3_WORD: idx = rvdec_pkg::IDX_SW;
          default:            idx = rvdec_pkg::IDX_NONE;
        endcase
      end
      rvdec_pkg::OP_IMM: begin
        fmt = rvdec_pkg::FMT_I;
        unique case (f3)
          rvdec_pkg::F3_ADD:  idx = rvdec_pkg::IDX_ADDI;
          rvdec_pkg::F3_SLT:  idx = rvdec_pkg::IDX_SLTI;
          rvdec_pkg::F3_SLTU: idx = rvdec_pkg::IDX_SLTIU;
          rvdec_pkg::F3_XOR:  idx = rvdec_pkg::IDX_XORI;
          rvdec_pkg::F3_OR:   idx = rvdec_pkg::IDX_ORI;
          rvdec_pkg::F3_AND:  idx = rvdec_pkg::IDX_ANDI;
          // only bit 30 of funct7 is looked at for the shifts
          rvdec_pkg::F3_SLL:  idx = alt ? rvdec_pkg::IDX_NONE : rvdec_pkg::IDX_SLLI;
          rvdec_pkg::F3_SR:   idx = alt ? rvdec_pkg::IDX_SRAI : rvdec_pkg::IDX_SRLI;
          default:            idx = rvdec_pkg::IDX_NONE;
        endcase
      end
      rvdec_pkg::OP_REG: begin
        fmt = rvdec_pkg::FMT_R;
        unique case (f3)
          rvdec_pkg::F3_ADD:  idx = alt ? rvdec_pkg::IDX_SUB : rvdec_pkg::IDX_ADD;
          rvdec_pkg::F3_SR:   idx = alt ? rvdec_pkg::IDX_SRA : rvdec_pkg::IDX_SRL;
          rvdec_pkg::F3_SLL:  idx = alt ? rvdec_pkg::IDX_NONE : rvdec_pkg::IDX_SLL;
          rvdec_pkg::F3_SLT:  idx = alt ? rvdec_pkg::IDX_NONE : rvdec_pkg::IDX_SLT;
          rvdec_pkg::F3_SLTU: idx = alt ? rvdec_pkg::IDX_NONE : rvdec_pkg::IDX_SLTU;
          rvdec_pkg::F3_XOR:  idx = alt ? rvdec_pkg::IDX_NONE : rvdec_pkg::IDX_XOR;
          rvdec_pkg::F3_OR:   idx = alt ? rvdec_pkg::IDX_NONE : rvdec_pkg::IDX_OR;
          rvdec_pkg::F3_AND:  idx = alt ? rvdec_pkg::IDX_NONE : rvdec_pkg::IDX_AND;
          default:            idx = rvdec_pkg::IDX_NONE;
        endcase
      end
      default: begin
        fmt = rvdec_pkg::FMT_BAD;
        idx = rvdec_pkg::IDX_NONE;
      end
    endcase
  end

  always_comb begin
    unique case (fmt)
      rvdec_pkg::FMT_I: imm = {{20{word_i[31]}}, word_i[31:20]};
      rvdec_pkg::FMT_S: imm = {{20{word_i[31]}}, word_i[31:25], word_i[11:7]};
      rvdec_pkg::FMT_B: imm = {{20{word_i[31]}}, word_i[7], word_i[30:25], word_i[11:8], 1'b0};
      rvdec_pkg::FMT_U: imm = {word_i[31:12], 12'h000};
      rvdec_pkg::FMT_J: imm = {{12{word_i[31]}}, word_i[19:12], word_i[20], word_i[30:21],
                               1'b0};
      default:          imm = '0;
    endcase
  end

  assign res_o.fmt = fmt;
  assign res_o.imm = imm;
  assign res_o.idx = idx;

endmodule

`default_nettype wire

>>> design/rvdec_out_stage.sv
// result register: holds one decoded result until the consumer takes it
// depends on rvdec_pkg and rvdec_out_if
`default_nettype none

module rvdec_out_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  rvdec_pkg::rvdec_res_t      res_i,
  output logic                       ready_o,
  rvdec_out_if.source                rsp_o
);

  logic                  valid_q, valid_d;
  rvdec_pkg::rvdec_res_t res_q;

  assign ready_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign rsp_o.valid       = valid_q;
  assign rsp_o.format_code = res_q.fmt;
  assign rsp_o.immediate   = res_q.imm;
  assign rsp_o.instr_index = res_q.idx;

endmodule

`default_nettype wire

>>> design/rv32i_instruction_decoder.sv
// rv32i instruction decoder top level: input register, decode logic, result register
// depends on rvdec_pkg, rvdec_in_if, rvdec_out_if, rvdec_in_stage, rvdec_decode,
// rvdec_out_stage and rv32i_instruction_decoder_assert.svh
//
//   port    dir  payload                                            per request
//   req_i   in   instr_word[31:0]                                   one word
//   rsp_o   out  format_code[2:0] immediate[31:0] instr_index[5:0]  one result
//
// one request per cycle sustained while rsp_o does not stall; an accepted word is held
// in the input register, decoded, and its result held in the result register for rsp_o
// throughput is set by the two register stages, each refilled every cycle if no stall
// reset clears only the valid flags of both stages, payload registers are not reset
// a stall on rsp_o fills the result register, then the input register, then drops ready
`default_nettype none
`include "rv32i_instruction_decoder_assert.svh"

module rv32i_instruction_decoder (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rvdec_in_if.sink    req_i,
  rvdec_out_if.source rsp_o
);

  logic                         stage_valid;
  logic [rvdec_pkg::WORD_W-1:0] stage_word;
  logic                         out_ready;
  rvdec_pkg::rvdec_res_t        dec_res;

  rvdec_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .down_ready_i (out_ready),
    .valid_o      (stage_valid),
    .word_o       (stage_word)
  );

  rvdec_decode u_decode (
    .word_i (stage_word),
    .res_o  (dec_res)
  );

  rvdec_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid),
    .res_i   (dec_res),
    .ready_o (out_ready),
    .rsp_o   (rsp_o)
  );

  `RVDEC_ASSERT_NEXT(a_stage_advance, stage_valid && out_ready, rsp_o.valid,
                     "decoded word did not reach the result register")
  `RVDEC_ASSERT_NOW(a_no_imm_for_r, rsp_o.valid &&
                    (rsp_o.format_code == rvdec_pkg::FMT_R ||
                     rsp_o.format_code == rvdec_pkg::FMT_BAD),
                    rsp_o.immediate == '0, "nonzero immediate for R or invalid format")
  `RVDEC_ASSERT_NOW(a_bad_has_no_index, rsp_o.valid && rsp_o.format_code == rvdec_pkg::FMT_BAD,
                    rsp_o.instr_index == rvdec_pkg::IDX_NONE,
                    "instruction index given for an invalid format")
  `RVDEC_ASSERT_NOW(a_u_low_zero, rsp_o.valid && rsp_o.format_code == rvdec_pkg::FMT_U,
                    rsp_o.immediate[11:0] == 12'h000, "U immediate low bits not zero")

endmodule

`default_nettype wire
